// ----- src/swrl_pkg.sv -----
// Shared types and constants for the sliding-window rate limiter.
`default_nettype none

package swrl_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned LIM_W      = 5;
  localparam int unsigned LIVE_W     = 5;
  localparam int unsigned FLOW_IN_W  = 8;
  localparam int unsigned ROUTE_IN_W = 2;
  localparam int unsigned NUM_ROUTES = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(60);
  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(10);

  // low bit of the register index picks the field of a route pair
  localparam logic CFG_FIELD_WINDOW = 1'b0;
  localparam logic CFG_FIELD_LIMIT  = 1'b1;

  typedef struct packed {
    logic [WIN_W-1:0] window;
    logic [LIM_W-1:0] limit;
  } route_cfg_t;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_META   = 5'b00100,
    S_SCAN   = 5'b01000,
    S_DECIDE = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// ----- src/swrl_cfg_regs.sv -----
// Route window and limit registers with route selection.
`default_nettype none

module swrl_cfg_regs
  import swrl_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [ROUTE_IN_W-1:0] route_i,
  output route_cfg_t                 route_cfg_o
);

  logic [WIN_W-1:0] win_q [NUM_ROUTES];
  logic [LIM_W-1:0] lim_q [NUM_ROUTES];
  logic [ROUTE_IN_W-1:0] wr_route;

  assign wr_route = cfg_idx_i[CFG_IDX_W-1:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_ROUTES; r++) begin
        win_q[r] <= WIN_RESET;
        lim_q[r] <= LIM_RESET;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i[0])
        CFG_FIELD_WINDOW: win_q[wr_route] <= cfg_data_i[WIN_W-1:0];
        CFG_FIELD_LIMIT:  lim_q[wr_route] <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign route_cfg_o.window = win_q[route_i];
  assign route_cfg_o.limit  = lim_q[route_i];

endmodule

`default_nettype wire

// ----- src/sliding_window_rate_limiter.sv -----
// Sliding-window-log rate limiter: per-flow timestamp rings in block memory.
//
//  channel  | dir | payload (low bit first)                         | handshake
//  s_axis   | in  | tuser: route_matched, route_index               | tvalid/tready
//           |     | tdata: flow_index[7:0], now_seconds[31:0]       |
//  m_axis   | out | tdata: allowed, live_count[4:0], 2 pad bits     | tvalid/tready
//  cfg      | in  | cfg_idx_i, cfg_data_i                           | cfg_we_i
//
// An unmatched item goes straight from acceptance to the decision. A matched
// item reads its flow entry, then examines S stamps (S at most MAX_REQ): the
// expired ones plus the first live one if any, one stamp read per cycle from the ring.
// After reset the flow table is cleared, one flow per cycle;
// no item is taken meanwhile, config writes are.
// A finished result waits in the output register; the next item is taken
// while it waits and stalls only at its own result if the register is full.
`default_nettype none

module sliding_window_rate_limiter
  import swrl_pkg::*;
#(
  parameter int unsigned FLOWS   = 256,
  parameter int unsigned MAX_REQ = 16,
  parameter int unsigned ROUTES  = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [39:0]           s_axis_tdata,  // flow_index[7:0], now_seconds[31:0]
  input  wire logic [2:0]            s_axis_tuser,  // route_matched, route_index[1:0]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [7:0]                 m_axis_tdata,  // allowed, live_count[4:0], zero pad
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned FLOW_W  = (FLOWS > 1) ? $clog2(FLOWS) : 1;
  localparam int unsigned HEAD_W  = (MAX_REQ > 1) ? $clog2(MAX_REQ) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_REQ + 1);
  localparam int unsigned DEPTH   = FLOWS * MAX_REQ;
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned META_W  = HEAD_W + CNT_W;
  localparam int unsigned SUM_W   = ((HEAD_W > CNT_W) ? HEAD_W : CNT_W) + 1;
  localparam int unsigned LW      = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam int unsigned FLOW_IN_N = 1 << FLOW_IN_W;
  localparam int unsigned ROUTE_IN_N = 1 << ROUTE_IN_W;

  // input field views
  logic                  in_matched;
  logic [ROUTE_IN_W-1:0] in_route;
  logic [FLOW_IN_W-1:0]  in_flow;
  logic [TIME_W-1:0]     in_now;

  assign in_matched = s_axis_tuser[0];
  assign in_route   = s_axis_tuser[2:1];
  assign in_flow    = s_axis_tdata[7:0];
  assign in_now     = s_axis_tdata[39:8];

  // index folding tables
  logic [FLOW_W-1:0]     flow_lut  [FLOW_IN_N];
  logic [ROUTE_IN_W-1:0] route_lut [ROUTE_IN_N];

  for (genvar g = 0; g < FLOW_IN_N; g++) begin : g_flow_lut
    assign flow_lut[g] = FLOW_W'(g % FLOWS);
  end
  for (genvar g = 0; g < ROUTE_IN_N; g++) begin : g_route_lut
    assign route_lut[g] = ROUTE_IN_W'(g % ROUTES);
  end

  // control and item registers
  state_e                state_q, state_d;
  logic [FLOW_W-1:0]     clr_q, clr_d;
  logic                  matched_q, matched_d;
  logic [ROUTE_IN_W-1:0] route_q, route_d;
  logic [FLOW_W-1:0]     flow_q, flow_d;
  logic [ADDR_W-1:0]     base_q, base_d;
  logic [TIME_W-1:0]     now_q, now_d;
  logic [HEAD_W-1:0]     head_q, head_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [WIN_W-1:0]      win_q, win_d;
  logic [CNT_W-1:0]      lim_q, lim_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_allowed_q, out_allowed_d;
  logic [LIVE_W-1:0]     out_count_q, out_count_d;

  route_cfg_t route_cfg;

  swrl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .route_i     (route_q),
    .route_cfg_o (route_cfg)
  );

  // memories
  logic [META_W-1:0] meta_mem [FLOWS];
  logic [TIME_W-1:0] stamp_mem [DEPTH];
  logic [META_W-1:0] meta_rdata_q;
  logic [TIME_W-1:0] stamp_rdata_q;

  logic              meta_re, meta_we;
  logic [FLOW_W-1:0] meta_raddr, meta_waddr;
  logic [META_W-1:0] meta_wdata;
  logic              stamp_re, stamp_we;
  logic [ADDR_W-1:0] stamp_raddr, stamp_waddr;

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (meta_re) begin
      meta_rdata_q <= meta_mem[meta_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stamp_we) begin
      stamp_mem[stamp_waddr] <= now_q;
    end
    if (stamp_re) begin
      stamp_rdata_q <= stamp_mem[stamp_raddr];
    end
  end

  // datapath
  logic [HEAD_W-1:0] meta_head, head_inc, slot;
  logic [CNT_W-1:0]  meta_cnt, cnt_new;
  logic [LW-1:0]     lim_ext, lim_sat;
  logic [TIME_W-1:0] age;
  logic              expired, grant, s_fire, decide_fire;
  logic [SUM_W-1:0]  slot_sum, slot_wrap;
  logic [CNT_W+LIVE_W-1:0] live_ext;

  assign meta_head = meta_rdata_q[META_W-1:CNT_W];
  assign meta_cnt  = meta_rdata_q[CNT_W-1:0];
  assign lim_ext   = LW'(route_cfg.limit);
  assign lim_sat   = (lim_ext > LW'(MAX_REQ)) ? LW'(MAX_REQ) : lim_ext;
  assign head_inc  = (head_q == HEAD_W'(MAX_REQ - 1)) ? '0 : head_q + 1'b1;
  assign age       = now_q - stamp_rdata_q;
  assign expired   = age >= TIME_W'(win_q);
  assign grant     = matched_q && (cnt_q < lim_q);
  assign cnt_new   = grant ? cnt_q + 1'b1 : cnt_q;
  assign slot_sum  = SUM_W'(head_q) + SUM_W'(cnt_q);
  assign slot_wrap = (slot_sum >= SUM_W'(MAX_REQ)) ? slot_sum - SUM_W'(MAX_REQ) : slot_sum;
  assign slot      = slot_wrap[HEAD_W-1:0];
  assign live_ext  = (CNT_W + LIVE_W)'(cnt_new);

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign decide_fire   = (state_q == S_DECIDE) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    matched_d     = matched_q;
    route_d       = route_q;
    flow_d        = flow_q;
    base_d        = base_q;
    now_d         = now_q;
    head_d        = head_q;
    cnt_d         = cnt_q;
    win_d         = win_q;
    lim_d         = lim_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_allowed_d = out_allowed_q;
    out_count_d   = out_count_q;
    meta_re       = 1'b0;
    meta_raddr    = flow_lut[in_flow];
    meta_we       = 1'b0;
    meta_waddr    = flow_q;
    meta_wdata    = {head_q, cnt_new};
    stamp_re      = 1'b0;
    stamp_raddr   = base_q + ADDR_W'(head_inc);
    stamp_we      = 1'b0;
    stamp_waddr   = base_q + ADDR_W'(slot);

    case (state_q)
      S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_q;
        meta_wdata = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == FLOW_W'(FLOWS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_fire) begin
          matched_d = in_matched;
          route_d   = route_lut[in_route];
          flow_d    = flow_lut[in_flow];
          base_d    = ADDR_W'(flow_lut[in_flow]) * ADDR_W'(MAX_REQ);
          now_d     = in_now;
          meta_re   = in_matched;
          state_d   = in_matched ? S_META : S_DECIDE;
        end
      end
      S_META: begin
        head_d      = meta_head;
        cnt_d       = meta_cnt;
        win_d       = route_cfg.window;
        lim_d       = CNT_W'(lim_sat);
        stamp_re    = (meta_cnt != '0);
        stamp_raddr = base_q + ADDR_W'(meta_head);
        state_d     = (meta_cnt != '0) ? S_SCAN : S_DECIDE;
      end
      S_SCAN: begin
        if (expired) begin
          head_d = head_inc;
          cnt_d  = cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            state_d = S_DECIDE;
          end else begin
            stamp_re = 1'b1;
          end
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (decide_fire) begin
          meta_we       = matched_q;
          stamp_we      = grant;
          cnt_d         = cnt_new;
          out_valid_d   = 1'b1;
          out_allowed_d = !matched_q || grant;
          out_count_d   = matched_q ? live_ext[LIVE_W-1:0] : '0;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q     <= matched_d;
    route_q       <= route_d;
    flow_q        <= flow_d;
    base_q        <= base_d;
    now_q         <= now_d;
    head_q        <= head_d;
    cnt_q         <= cnt_d;
    win_q         <= win_d;
    lim_q         <= lim_d;
    out_allowed_q <= out_allowed_d;
    out_count_q   <= out_count_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_count_q, out_allowed_q};

  // checks
  a_no_result_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !m_axis_tvalid)
    else $error("result produced during flow table clear");

  a_matched_reads_meta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && in_matched) |=> (state_q == S_META))
    else $error("matched item did not start with a flow table read");

  a_scan_has_stamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cnt_q != '0) && (cnt_q <= CNT_W'(MAX_REQ)))
    else $error("expiry scan with empty or overfull ring");

  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  a_grant_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (decide_fire && grant) |-> (cnt_new <= lim_q))
    else $error("allowed item exceeds route limit");

endmodule

`default_nettype wire
